### hdl/relative_path_validator_macros.svh
// Assertion macros for the relative path validator.
`ifndef RELATIVE_PATH_VALIDATOR_MACROS_SVH
`define RELATIVE_PATH_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RPV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("relative_path_validator: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define RPV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("relative_path_validator: assertion failed");

`endif

### hdl/rpv_pkg.sv
// Package of the relative path validator: types, codes and constants.
`default_nettype none

package rpv_pkg;

    localparam int PATH_LIMIT_BITS_DEF = 12;
    localparam int DEPTH_LIMIT_DEF     = 64;

    localparam int BYTE_W       = 8;
    localparam int VERDICT_W    = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int LEN_CFG_W    = 12;
    localparam int COMPS_CFG_W  = 7;
    localparam int COMP_LEN_W   = 13;

    localparam logic [LEN_CFG_W-1:0]   MAX_PATH_LENGTH_RST      = 12'd1024;
    localparam logic [LEN_CFG_W-1:0]   MAX_COMPONENT_LENGTH_RST = 12'd255;
    localparam logic [COMPS_CFG_W-1:0] MAX_COMPONENTS_RST       = 7'd32;
    localparam logic                   ALLOW_HIDDEN_RST         = 1'b0;

    localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_DEL       = 8'h7F;
    localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_DOT       = 8'h2E;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OK     = 2'd0,
        VERDICT_FORMAT = 2'd1,
        VERDICT_LIMIT  = 2'd2
    } t_verdict;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_PATH_LENGTH      = 2'd0,
        CFG_MAX_COMPONENT_LENGTH = 2'd1,
        CFG_MAX_COMPONENTS       = 2'd2,
        CFG_ALLOW_HIDDEN         = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_CFG_W-1:0]   max_path_length;
        logic [LEN_CFG_W-1:0]   max_component_length;
        logic [COMPS_CFG_W-1:0] max_components;
        logic                   allow_hidden;
    } t_cfg;

endpackage

`default_nettype wire

### hdl/rpv_stream_if.sv
// Stream interfaces of the relative path validator: path bytes in, verdicts out.
`default_nettype none

interface rpv_byte_if;
    logic                      valid;
    logic                      ready;
    logic [rpv_pkg::BYTE_W-1:0] path_byte;

    modport source (output valid, output path_byte, input ready);
    modport sink   (input valid, input path_byte, output ready);
endinterface

interface rpv_verdict_if;
    logic                         valid;
    logic                         ready;
    logic [rpv_pkg::VERDICT_W-1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

### hdl/rpv_cfg_regs.sv
// Configuration register file of the relative path validator.
`default_nettype none

module rpv_cfg_regs #(
    parameter int PATH_LIMIT_BITS = rpv_pkg::PATH_LIMIT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rpv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rpv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output rpv_pkg::t_cfg                       o_cfg
);

    // Only the low PATH_LIMIT_BITS bits of the path limit take effect.
    localparam int MASK_W = (PATH_LIMIT_BITS < rpv_pkg::LEN_CFG_W) ?
                            PATH_LIMIT_BITS : rpv_pkg::LEN_CFG_W;
    localparam logic [rpv_pkg::LEN_CFG_W-1:0] PATH_MASK =
        rpv_pkg::LEN_CFG_W'((64'd1 << MASK_W) - 64'd1);

    rpv_pkg::t_cfg r_cfg;
    rpv_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (rpv_pkg::t_cfg_idx'(i_cfg_idx))
                rpv_pkg::CFG_MAX_PATH_LENGTH: begin
                    n_cfg.max_path_length = i_cfg_data[rpv_pkg::LEN_CFG_W-1:0] & PATH_MASK;
                end
                rpv_pkg::CFG_MAX_COMPONENT_LENGTH: begin
                    n_cfg.max_component_length = i_cfg_data[rpv_pkg::LEN_CFG_W-1:0];
                end
                rpv_pkg::CFG_MAX_COMPONENTS: begin
                    n_cfg.max_components = i_cfg_data[rpv_pkg::COMPS_CFG_W-1:0];
                end
                rpv_pkg::CFG_ALLOW_HIDDEN: begin
                    n_cfg.allow_hidden = i_cfg_data[0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_path_length      <= rpv_pkg::MAX_PATH_LENGTH_RST;
            r_cfg.max_component_length <= rpv_pkg::MAX_COMPONENT_LENGTH_RST;
            r_cfg.max_components       <= rpv_pkg::MAX_COMPONENTS_RST;
            r_cfg.allow_hidden         <= rpv_pkg::ALLOW_HIDDEN_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hdl/relative_path_validator.sv
// Top level of the relative path validator: byte scanner and verdict register.
//
// Usage:
//   i_byte carries one path byte per transfer (valid/ready). A zero byte ends
//   the path; only that byte produces a transfer on o_verdict, which carries
//   0 (ok), 1 (format error) or 2 (limit exceeded).
//   The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) writes the path
//   length limit, component length limit, component count limit and the
//   hidden-component switch; write it only while no path is in flight.
// Throughput: one byte per clock while the verdict register is not stalled.
//   The scan state updates once per byte, which is the loop that sets this rate.
// Latency: the verdict is valid in the cycle after the terminator transfer.
// Stall: the verdict sits in an output register. While it waits and the
//   receiver holds o_verdict.ready low, i_byte.ready is low as well, so no
//   byte is taken until the verdict transfers; a ready receiver lets bytes
//   flow with no gap.
// Reset: synchronous, active low. Scan state and the output valid clear;
//   the registers return to 1024 / 255 / 32 / hidden not allowed.
`default_nettype none

`include "relative_path_validator_macros.svh"

module relative_path_validator #(
    parameter int PATH_LIMIT_BITS = rpv_pkg::PATH_LIMIT_BITS_DEF,
    parameter int DEPTH_LIMIT     = rpv_pkg::DEPTH_LIMIT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    rpv_byte_if.sink                            i_byte,
    rpv_verdict_if.source                       o_verdict,
    input  wire logic                           i_cfg_we,
    input  wire logic [rpv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rpv_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PL_W  = PATH_LIMIT_BITS + 1;          // holds 0 .. 2^PATH_LIMIT_BITS
    localparam int CMP_W = (PL_W > rpv_pkg::LEN_CFG_W) ? PL_W : rpv_pkg::LEN_CFG_W;
    localparam int DEP_W = $clog2(DEPTH_LIMIT + 1);
    localparam int CAP_W = (DEP_W > rpv_pkg::COMPS_CFG_W) ? DEP_W : rpv_pkg::COMPS_CFG_W;
    localparam int CL_W  = rpv_pkg::COMP_LEN_W;
    localparam int BYTE_W_L = rpv_pkg::BYTE_W;

    rpv_pkg::t_cfg w_cfg;

    rpv_cfg_regs #(
        .PATH_LIMIT_BITS(PATH_LIMIT_BITS)
    ) u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_cfg     (w_cfg)
    );

    // Scan state.
    logic [PL_W-1:0]   r_path_len,   n_path_len;
    logic [CL_W-1:0]   r_comp_len,   n_comp_len;
    logic              r_first_dot,  n_first_dot;
    logic              r_second_dot, n_second_dot;
    logic [DEP_W-1:0]  r_depth,      n_depth;
    rpv_pkg::t_verdict r_first_err,  n_first_err;
    logic              r_lead_slash, n_lead_slash;

    // Output register.
    logic              r_out_valid,  n_out_valid;
    rpv_pkg::t_verdict r_out_verdict, n_out_verdict;

    logic                    w_accept;
    logic                    w_term;
    logic [BYTE_W_L-1:0]     w_byte;
    logic                    w_rejected;
    logic [CAP_W-1:0]        w_cap;
    logic [CAP_W-1:0]        w_comps_ext;
    rpv_pkg::t_verdict       w_close_err;
    rpv_pkg::t_verdict       w_err_final;
    logic                    w_path_over;

    // Take a byte unless a verdict is stuck and a new one would land on it.
    assign i_byte.ready = !r_out_valid || o_verdict.ready;
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_byte       = i_byte.path_byte;
    assign w_term       = (w_byte == rpv_pkg::CHAR_NUL);

    assign w_rejected = (w_byte < rpv_pkg::CHAR_SPACE) || (w_byte == rpv_pkg::CHAR_DEL) ||
                        (w_byte == rpv_pkg::CHAR_BACKSLASH) ||
                        (w_byte == rpv_pkg::CHAR_COLON);

    // Depth cap: the component count register, clipped to the build limit.
    assign w_comps_ext = CAP_W'(w_cfg.max_components);
    assign w_cap       = (w_comps_ext > CAP_W'(DEPTH_LIMIT)) ? CAP_W'(DEPTH_LIMIT) : w_comps_ext;

    // Checks made when the current component closes, first match wins.
    always_comb begin
        priority if (r_comp_len == '0) begin
            w_close_err = rpv_pkg::VERDICT_FORMAT;
        end else if (r_comp_len > {1'b0, w_cfg.max_component_length}) begin
            w_close_err = rpv_pkg::VERDICT_LIMIT;
        end else if ((r_comp_len == CL_W'(1) && r_first_dot) ||
                     (r_comp_len == CL_W'(2) && r_first_dot && r_second_dot)) begin
            w_close_err = rpv_pkg::VERDICT_FORMAT;   // "." or ".."
        end else if (!w_cfg.allow_hidden && r_first_dot) begin
            w_close_err = rpv_pkg::VERDICT_FORMAT;   // hidden component
        end else if (CAP_W'(r_depth) == w_cap) begin
            w_close_err = rpv_pkg::VERDICT_LIMIT;    // too deep
        end else begin
            w_close_err = rpv_pkg::VERDICT_OK;
        end
    end

    assign w_err_final = (r_first_err != rpv_pkg::VERDICT_OK) ? r_first_err : w_close_err;
    assign w_path_over = CMP_W'(r_path_len) > CMP_W'(w_cfg.max_path_length);

    // Next scan state.
    always_comb begin
        n_path_len   = r_path_len;
        n_comp_len   = r_comp_len;
        n_first_dot  = r_first_dot;
        n_second_dot = r_second_dot;
        n_depth      = r_depth;
        n_first_err  = r_first_err;
        n_lead_slash = r_lead_slash;
        if (w_accept) begin
            if (w_term) begin
                // Drop all scan state once the verdict is formed.
                n_path_len   = '0;
                n_comp_len   = '0;
                n_first_dot  = 1'b0;
                n_second_dot = 1'b0;
                n_depth      = '0;
                n_first_err  = rpv_pkg::VERDICT_OK;
                n_lead_slash = 1'b0;
            end else begin
                if (r_path_len == '0 && w_byte == rpv_pkg::CHAR_SLASH) begin
                    n_lead_slash = 1'b1;
                end
                if (!r_path_len[PL_W-1]) begin
                    n_path_len = r_path_len + PL_W'(1);
                end
                // After the first error only the length advances.
                if (r_first_err == rpv_pkg::VERDICT_OK) begin
                    priority if (w_rejected) begin
                        n_first_err = rpv_pkg::VERDICT_FORMAT;
                    end else if (w_byte == rpv_pkg::CHAR_SLASH) begin
                        if (w_close_err != rpv_pkg::VERDICT_OK) begin
                            n_first_err = w_close_err;
                        end else begin
                            n_depth = r_depth + DEP_W'(1);
                        end
                        n_comp_len   = '0;
                        n_first_dot  = 1'b0;
                        n_second_dot = 1'b0;
                    end else begin
                        if (r_comp_len == '0) begin
                            n_first_dot = (w_byte == rpv_pkg::CHAR_DOT);
                        end else if (r_comp_len == CL_W'(1)) begin
                            n_second_dot = (w_byte == rpv_pkg::CHAR_DOT);
                        end
                        if (!r_comp_len[CL_W-1]) begin
                            n_comp_len = r_comp_len + CL_W'(1);
                        end
                    end
                end
            end
        end
    end

    // Verdict register: load on the terminator, release on the output transfer.
    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_verdict = r_out_verdict;
        if (w_accept && w_term) begin
            n_out_valid = 1'b1;
            priority if (w_path_over) begin
                n_out_verdict = rpv_pkg::VERDICT_LIMIT;
            end else if (r_path_len == '0 || r_lead_slash) begin
                n_out_verdict = rpv_pkg::VERDICT_FORMAT;
            end else begin
                n_out_verdict = w_err_final;
            end
        end else if (o_verdict.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len   <= '0;
            r_comp_len   <= '0;
            r_first_dot  <= 1'b0;
            r_second_dot <= 1'b0;
            r_depth      <= '0;
            r_first_err  <= rpv_pkg::VERDICT_OK;
            r_lead_slash <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_path_len   <= n_path_len;
            r_comp_len   <= n_comp_len;
            r_first_dot  <= n_first_dot;
            r_second_dot <= n_second_dot;
            r_depth      <= n_depth;
            r_first_err  <= n_first_err;
            r_lead_slash <= n_lead_slash;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_verdict <= n_out_verdict;
    end

    assign o_verdict.valid   = r_out_valid;
    assign o_verdict.verdict = r_out_verdict;

    // A terminator transfer always leaves a verdict waiting and a clean scan.
    `RPV_ASSERT_NEXT(a_term_gives_verdict, i_clk, i_rst_n, w_accept && w_term, r_out_valid)
    `RPV_ASSERT_NEXT(a_term_clears_scan, i_clk, i_rst_n, w_accept && w_term, r_path_len == '0 && r_depth == '0)
    // Depth never passes the cap while a path is scanned.
    `RPV_ASSERT_NOW(a_depth_in_cap, i_clk, i_rst_n, 1'b1, CAP_W'(r_depth) <= w_cap)

endmodule

`default_nettype wire
